### design/sakc_pkg.sv
// Shared types and constants for the sorted array key counter.
// Holds op codes, result field widths and the controller/datapath command
// and status structs. No dependencies.
package sakc_pkg;

    localparam int OP_W = 2;
    localparam int OUT_CNT_W = 11;
    localparam int OUT_POS_W = 10;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic load;        // append item_value to the array
        logic clear;       // empty the array
        logic start;       // latch key, open the first-edge search
        logic start_last;  // open the last-edge search
        logic rd_mid;      // read the probe entry
        logic rd_nbr;      // read the neighbor of the probe entry
        logic go_left;     // hi = mid - 1
        logic go_right;    // lo = mid + 1
        logic hit;         // record mid as the edge of the current search
        logic out_load;    // capture the result into the output register
    } sakc_cmd_t;

    typedef struct packed {
        logic range_ok;    // lo <= hi
        logic eq;          // read data equals key
        logic gt;          // read data above key
        logic at_edge;     // mid sits on the search bound (lo or hi)
        logic pass_last;   // searching for the last edge
        logic full;        // array holds DEPTH entries
    } sakc_stat_t;

endpackage

### design/sakc_ctrl.sv
// Controller for the sorted array key counter: sequences the two binary
// searches and owns the handshakes. Depends on sakc_pkg.
module sakc_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sakc_pkg::OP_W-1:0]   s_op,
    output logic                        m_valid,
    input  logic                        m_ready,
    output sakc_pkg::sakc_cmd_t         cmd,
    input  sakc_pkg::sakc_stat_t        stat
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PROBE = 5'b00010,
        ST_CMP   = 5'b00100,
        ST_NBR   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        logic end_pass;
        end_pass   = 1'b0;
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_op)
                        sakc_pkg::OP_LOAD:  cmd.load = !stat.full;
                        sakc_pkg::OP_CLEAR: cmd.clear = 1'b1;
                        sakc_pkg::OP_QUERY: begin
                            cmd.start  = 1'b1;
                            state_next = ST_PROBE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PROBE: begin
                if (stat.range_ok) begin
                    cmd.rd_mid = 1'b1;
                    state_next = ST_CMP;
                end else begin
                    end_pass = 1'b1;
                end
            end
            ST_CMP: begin
                if (stat.eq) begin
                    if (stat.at_edge) begin
                        cmd.hit  = 1'b1;
                        end_pass = 1'b1;
                    end else begin
                        cmd.rd_nbr = 1'b1;
                        state_next = ST_NBR;
                    end
                end else if (stat.gt) begin
                    cmd.go_left = 1'b1;
                    state_next  = ST_PROBE;
                end else begin
                    cmd.go_right = 1'b1;
                    state_next   = ST_PROBE;
                end
            end
            ST_NBR: begin
                if (!stat.eq) begin
                    cmd.hit  = 1'b1;
                    end_pass = 1'b1;
                end else begin
                    // neighbor still matches: keep narrowing toward the edge
                    cmd.go_right = stat.pass_last;
                    cmd.go_left  = !stat.pass_last;
                    state_next   = ST_PROBE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (end_pass) begin
            if (stat.pass_last) begin
                state_next = ST_DONE;
            end else begin
                cmd.start_last = 1'b1;
                state_next     = ST_PROBE;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### design/sakc_dpath.sv
// Datapath for the sorted array key counter: element memory, fill count,
// search bounds, compare and result registers. Depends on sakc_pkg.
module sakc_dpath #(
    parameter int DEPTH       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic signed [VALUE_WIDTH-1:0]         item_value,
    input  logic signed [VALUE_WIDTH-1:0]         search_key,
    input  sakc_pkg::sakc_cmd_t                   cmd,
    output sakc_pkg::sakc_stat_t                  stat,
    output logic        [sakc_pkg::OUT_CNT_W-1:0] match_count,
    output logic        [sakc_pkg::OUT_POS_W-1:0] first_pos,
    output logic        [sakc_pkg::OUT_POS_W-1:0] last_pos,
    output logic                                  found
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PW    = CNT_W + 1;

    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic signed [VALUE_WIDTH-1:0] rdata_reg;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;

    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic signed [VALUE_WIDTH-1:0] key_reg;
    logic signed [PW-1:0]    lo_reg, lo_next, hi_reg, hi_next;
    logic [IDX_W-1:0]        mid_reg;
    logic                    pass_reg;
    logic [IDX_W-1:0]        first_reg, last_reg;
    logic                    f_ok_reg, l_ok_reg;

    logic [PW:0]             sum;
    logic [IDX_W-1:0]        mid_w;
    logic signed [PW-1:0]    mid_ext, fill_ext;
    logic [CNT_W-1:0]        count_w;
    logic                    hit_ok;

    logic [sakc_pkg::OUT_CNT_W-1:0] cnt_out_reg;
    logic [sakc_pkg::OUT_POS_W-1:0] first_out_reg, last_out_reg;
    logic                           found_out_reg;

    // lo and hi are both non-negative whenever a probe is issued
    assign sum      = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_w    = sum[IDX_W:1];
    assign mid_ext  = signed'({{(PW - IDX_W){1'b0}}, mid_reg});
    assign fill_ext = signed'({1'b0, fill_reg});

    assign rd_en   = cmd.rd_mid || cmd.rd_nbr;
    always_comb begin
        rd_addr = mid_w;
        if (cmd.rd_nbr) begin
            rd_addr = pass_reg ? (mid_reg + 1'b1) : (mid_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mem[fill_reg[IDX_W-1:0]] <= item_value;
        end
        if (rd_en) begin
            rdata_reg <= signed'(mem[rd_addr]);
        end
    end

    assign stat.range_ok  = (lo_reg <= hi_reg);
    assign stat.eq        = (rdata_reg == key_reg);
    assign stat.gt        = (rdata_reg > key_reg);
    assign stat.at_edge   = pass_reg ? (mid_ext == hi_reg) : (mid_ext == lo_reg);
    assign stat.pass_last = pass_reg;
    assign stat.full      = (fill_reg == CNT_W'(DEPTH));

    always_comb begin
        fill_next = fill_reg;
        if (cmd.clear) begin
            fill_next = '0;
        end else if (cmd.load) begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.start || cmd.start_last) begin
            lo_next = '0;
            hi_next = fill_ext - PW'(1);
        end else if (cmd.go_left) begin
            hi_next = mid_ext - PW'(1);
        end else if (cmd.go_right) begin
            lo_next = mid_ext + PW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (cmd.rd_mid) begin
            mid_reg <= mid_w;
        end
        if (cmd.start) begin
            key_reg  <= search_key;
            pass_reg <= 1'b0;
            f_ok_reg <= 1'b0;
            l_ok_reg <= 1'b0;
        end else if (cmd.start_last) begin
            pass_reg <= 1'b1;
        end
        if (cmd.hit) begin
            if (pass_reg) begin
                last_reg <= mid_reg;
                l_ok_reg <= 1'b1;
            end else begin
                first_reg <= mid_reg;
                f_ok_reg  <= 1'b1;
            end
        end
    end

    assign hit_ok  = f_ok_reg && l_ok_reg && (last_reg >= first_reg);
    assign count_w = CNT_W'(last_reg) - CNT_W'(first_reg) + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            found_out_reg <= hit_ok;
            cnt_out_reg   <= hit_ok ? sakc_pkg::OUT_CNT_W'(count_w) : '0;
            first_out_reg <= hit_ok ? sakc_pkg::OUT_POS_W'(first_reg) : '0;
            last_out_reg  <= hit_ok ? sakc_pkg::OUT_POS_W'(last_reg) : '0;
        end
    end

    assign match_count = cnt_out_reg;
    assign first_pos   = first_out_reg;
    assign last_pos    = last_out_reg;
    assign found       = found_out_reg;

endmodule

### design/sorted_array_key_count.sv
// Top level of the sorted array key counter.
// Joins sakc_ctrl and sakc_dpath; depends on sakc_pkg.
//
// Holds an ascending array of up to DEPTH signed words. A load beat (op 0)
// appends one element, a load into a full array is dropped; a clear beat
// (op 2) empties the array; op 3 is ignored.
// A query beat (op 1) runs two binary searches, one for the first and one
// for the last index of the key, and returns one result beat with the match
// count, both indices and a found flag (all zero when the key is absent or
// the array is empty). Each probe reads the single memory read port with
// its registered output; when the probe hits the key and its neighbor must
// be checked, the neighbor is read as well. A pass closes when its search
// range runs out. The block takes one beat at a time; a finished result
// waits in the output register while further beats are accepted.
module sorted_array_key_count #(
    parameter int DEPTH       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic        [sakc_pkg::OP_W-1:0]      s_op,
    input  logic signed [VALUE_WIDTH-1:0]         s_item_value,
    input  logic signed [VALUE_WIDTH-1:0]         s_search_key,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic        [sakc_pkg::OUT_CNT_W-1:0] m_match_count,
    output logic        [sakc_pkg::OUT_POS_W-1:0] m_first_pos,
    output logic        [sakc_pkg::OUT_POS_W-1:0] m_last_pos,
    output logic                                  m_found
);

    sakc_pkg::sakc_cmd_t  cmd;
    sakc_pkg::sakc_stat_t stat;

    sakc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    sakc_dpath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_value  (s_item_value),
        .search_key  (s_search_key),
        .cmd         (cmd),
        .stat        (stat),
        .match_count (m_match_count),
        .first_pos   (m_first_pos),
        .last_pos    (m_last_pos),
        .found       (m_found)
    );

endmodule

### tb/sv/sorted_array_key_count_test.sv
// Self-checking testbench for sorted_array_key_count: loads, clears and key queries
// against an in-bench binary search predictor, with random idling and back-pressure.
// Depends on sakc_pkg and the sorted_array_key_count RTL.
module sorted_array_key_count_test;

    localparam int DEPTH = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam logic [sakc_pkg::OP_W-1:0] OP_SPARE = 2'd3;
    localparam logic [VALUE_WIDTH-1:0] SIGN_FLIP = 32'h8000_0000;
    localparam longint MAX_VALUE = 64'sd2147483647;
    localparam longint MIN_VALUE = -64'sd2147483648;
    localparam int RANDOM_BEATS = 60;
    localparam int QUIET_TAIL = 80;
    localparam int HOLD_AT = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [sakc_pkg::OP_W-1:0] op;
        logic [VALUE_WIDTH-1:0]    item_value;
        logic [VALUE_WIDTH-1:0]    search_key;
    } beat_t;

    typedef struct {
        logic [sakc_pkg::OUT_CNT_W-1:0] match_count;
        logic [sakc_pkg::OUT_POS_W-1:0] first_pos;
        logic [sakc_pkg::OUT_POS_W-1:0] last_pos;
        logic                           found;
    } key_count_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [sakc_pkg::OP_W-1:0] s_op = sakc_pkg::OP_LOAD;
    logic signed [VALUE_WIDTH-1:0] s_item_value = '0;
    logic signed [VALUE_WIDTH-1:0] s_search_key = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [sakc_pkg::OUT_CNT_W-1:0] m_match_count;
    logic [sakc_pkg::OUT_POS_W-1:0] m_first_pos;
    logic [sakc_pkg::OUT_POS_W-1:0] m_last_pos;
    logic m_found;

    sorted_array_key_count #(
        .DEPTH(DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_item_value(s_item_value),
        .s_search_key(s_search_key),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_match_count(m_match_count),
        .m_first_pos(m_first_pos),
        .m_last_pos(m_last_pos),
        .m_found(m_found)
    );

    // Predictor state: order keys (sign bit flipped) so unsigned compare follows signed order.
    logic [VALUE_WIDTH-1:0] order_mem [0:DEPTH-1];
    int fill_cnt = 0;

    beat_t pending_beats[$];
    key_count_t count_expect[$];
    logic [VALUE_WIDTH-1:0] set_vals[$];
    int beats_queued = 0;
    int errors = 0;
    int results_seen = 0;
    int cycle_cnt = 0;
    logic rx_hold = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int search_edge(logic [VALUE_WIDTH-1:0] key, bit want_last);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = fill_cnt - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (order_mem[mid] == key) begin
                if (!want_last) begin
                    if (mid == lo || order_mem[mid-1] != key) return mid;
                    hi = mid - 1;
                end else begin
                    if (mid == hi || order_mem[mid+1] != key) return mid;
                    lo = mid + 1;
                end
            end else if (order_mem[mid] > key) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return -1;
    endfunction

    task automatic apply_beat(input beat_t b);
        key_count_t r;
        int f;
        int l;
        case (b.op)
            sakc_pkg::OP_LOAD: begin
                // drop when full
                if (fill_cnt < DEPTH) begin
                    order_mem[fill_cnt] = b.item_value ^ SIGN_FLIP;
                    fill_cnt++;
                end
            end
            sakc_pkg::OP_CLEAR: fill_cnt = 0;
            sakc_pkg::OP_QUERY: begin
                r = '{default: '0};
                if (fill_cnt > 0) begin
                    f = search_edge(b.search_key ^ SIGN_FLIP, 1'b0);
                    l = search_edge(b.search_key ^ SIGN_FLIP, 1'b1);
                    if (f >= 0 && l >= f) begin
                        r.match_count = sakc_pkg::OUT_CNT_W'(l - f + 1);
                        r.first_pos = sakc_pkg::OUT_POS_W'(f);
                        r.last_pos = sakc_pkg::OUT_POS_W'(l);
                        r.found = 1'b1;
                    end
                end
                count_expect.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic push_beat(input logic [sakc_pkg::OP_W-1:0] op,
                             input logic [VALUE_WIDTH-1:0] v,
                             input logic [VALUE_WIDTH-1:0] k);
        beat_t b;
        b.op = op;
        b.item_value = v;
        b.search_key = k;
        pending_beats.push_back(b);
        if (op != OP_SPARE) beats_queued++;
    endtask

    task automatic add_noise();
        case ($urandom_range(0, 5))
            0: push_beat(sakc_pkg::OP_LOAD, $urandom, $urandom);
            1: push_beat(sakc_pkg::OP_CLEAR, $urandom, $urandom);
            2: push_beat(sakc_pkg::OP_QUERY, $urandom, $urandom);
            default: push_beat(OP_SPARE, $urandom, $urandom);
        endcase
    endtask

    task automatic add_query();
        logic [VALUE_WIDTH-1:0] k;
        int pick;
        pick = $urandom_range(0, 9);
        if (set_vals.size() == 0 || pick >= 8) k = $urandom;
        else if (pick == 7) k = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
        else if (pick == 6) k = set_vals[$urandom_range(0, set_vals.size() - 1)]
                              + (($urandom_range(0, 1) != 0) ? 32'd1 : 32'hffff_ffff);
        else k = set_vals[$urandom_range(0, set_vals.size() - 1)];
        push_beat(sakc_pkg::OP_QUERY, $urandom, k);
    endtask

    // One data set: optional clear, ascending loads (a few shuffled), then queries.
    task automatic build_set(input int n);
        longint v;
        int mode;
        int i;
        int a;
        int b;
        logic [VALUE_WIDTH-1:0] t;
        set_vals.delete();
        mode = $urandom_range(0, 3);
        case (mode)
            2: v = MAX_VALUE - longint'($urandom_range(0, 30));
            3: v = MIN_VALUE;
            default: v = longint'($signed($urandom));
        endcase
        for (i = 0; i < n; i++) begin
            if (v > MAX_VALUE) v = MAX_VALUE;
            set_vals.push_back(v[VALUE_WIDTH-1:0]);
            if (mode == 1) v += longint'($urandom_range(0, 65536));
            else v += longint'($urandom_range(0, 2));
        end
        if (n > 1 && $urandom_range(0, 9) == 0) begin
            for (i = 0; i < 3; i++) begin
                a = $urandom_range(0, n - 1);
                b = $urandom_range(0, n - 1);
                t = set_vals[a];
                set_vals[a] = set_vals[b];
                set_vals[b] = t;
            end
        end
        // append to the previous set now and then
        if ($urandom_range(0, 9) != 0) push_beat(sakc_pkg::OP_CLEAR, $urandom, $urandom);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 39) == 0) add_noise();
            push_beat(sakc_pkg::OP_LOAD, set_vals[i], $urandom);
        end
        for (i = $urandom_range(1, 8); i > 0; i--) begin
            if ($urandom_range(0, 19) == 0) add_noise();
            add_query();
        end
    endtask

    // Driver: offer pending beats, predict each one at its handshake.
    int tx_gap = 0;
    always @(posedge aclk) begin
        beat_t b;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                b.op = s_op;
                b.item_value = s_item_value;
                b.search_key = s_search_key;
                apply_beat(b);
            end
            if (!s_valid || s_ready) begin
                if (tx_gap == 0 && pending_beats.size() > QUIET_TAIL
                        && (pending_beats.size() / 200) % 3 != 2
                        && $urandom_range(0, 7) == 0)
                    tx_gap = $urandom_range(1, 12);
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    b = pending_beats.pop_front();
                    s_op <= b.op;
                    s_item_value <= b.item_value;
                    s_search_key <= b.search_key;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off so the block backs up and drops s_ready.
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_hold <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rx_hold <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) rx_hold <= 1'b0;
        end
    end

    // Monitor: check each result beat against the oldest expectation.
    int rx_gap = 0;
    always @(posedge aclk) begin
        key_count_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (count_expect.size() == 0) begin
                    $display("%0t: unexpected result beat count=%0d first=%0d last=%0d found=%0b",
                             $time, m_match_count, m_first_pos, m_last_pos, m_found);
                    errors++;
                end else begin
                    e = count_expect.pop_front();
                    if (m_match_count !== e.match_count) begin
                        $display("%0t: match_count expected %0d actual %0d",
                                 $time, e.match_count, m_match_count);
                        errors++;
                    end
                    if (m_first_pos !== e.first_pos) begin
                        $display("%0t: first_pos expected %0d actual %0d",
                                 $time, e.first_pos, m_first_pos);
                        errors++;
                    end
                    if (m_last_pos !== e.last_pos) begin
                        $display("%0t: last_pos expected %0d actual %0d",
                                 $time, e.last_pos, m_last_pos);
                        errors++;
                    end
                    if (m_found !== e.found) begin
                        $display("%0t: found expected %0b actual %0b", $time, e.found, m_found);
                        errors++;
                    end
                end
            end
            if (rx_gap == 0 && pending_beats.size() > QUIET_TAIL
                    && (results_seen / 60) % 3 != 1 && $urandom_range(0, 5) == 0)
                rx_gap = $urandom_range(1, 12);
            if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !rx_hold;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [VALUE_WIDTH-1:0] x;
        int i;

        // directed: empty array, extremes, duplicates, absent keys, clear, unsorted, spare op
        push_beat(sakc_pkg::OP_QUERY, $urandom, 32'd0);
        push_beat(OP_SPARE, 32'hffff_ffff, 32'hffff_ffff);
        push_beat(sakc_pkg::OP_LOAD, 32'h8000_0000, $urandom);
        push_beat(sakc_pkg::OP_LOAD, 32'h8000_0000, $urandom);
        push_beat(sakc_pkg::OP_LOAD, -32'sd5, $urandom);
        push_beat(sakc_pkg::OP_LOAD, 32'd0, $urandom);
        push_beat(sakc_pkg::OP_LOAD, 32'd0, $urandom);
        push_beat(sakc_pkg::OP_LOAD, 32'd0, $urandom);
        push_beat(sakc_pkg::OP_LOAD, 32'h7fff_ffff, $urandom);
        push_beat(sakc_pkg::OP_QUERY, $urandom, 32'h8000_0000);
        push_beat(sakc_pkg::OP_QUERY, $urandom, 32'd0);
        push_beat(sakc_pkg::OP_QUERY, $urandom, 32'h7fff_ffff);
        push_beat(sakc_pkg::OP_QUERY, $urandom, 32'd1);
        push_beat(sakc_pkg::OP_QUERY, $urandom, -32'sd5);
        push_beat(OP_SPARE, $urandom, $urandom);
        push_beat(sakc_pkg::OP_CLEAR, $urandom, $urandom);
        push_beat(sakc_pkg::OP_QUERY, $urandom, 32'd0);
        push_beat(sakc_pkg::OP_LOAD, 32'd7, $urandom);
        push_beat(sakc_pkg::OP_LOAD, 32'd3, $urandom);
        push_beat(sakc_pkg::OP_LOAD, 32'd9, $urandom);
        push_beat(sakc_pkg::OP_QUERY, $urandom, 32'd3);
        push_beat(sakc_pkg::OP_QUERY, $urandom, 32'd9);
        push_beat(sakc_pkg::OP_CLEAR, $urandom, $urandom);
        push_beat(sakc_pkg::OP_LOAD, 32'd42, $urandom);
        push_beat(sakc_pkg::OP_QUERY, $urandom, 32'd42);

        beats_queued = 0;
        while (beats_queued < RANDOM_BEATS)
            build_set(($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                   : $urandom_range(0, 40));

        // fill to capacity with one value, then two loads that must be dropped
        x = $urandom;
        push_beat(sakc_pkg::OP_CLEAR, $urandom, $urandom);
        for (i = 0; i < DEPTH; i++) push_beat(sakc_pkg::OP_LOAD, x, $urandom);
        push_beat(sakc_pkg::OP_LOAD, x + 32'd1, $urandom);
        push_beat(sakc_pkg::OP_LOAD, x + 32'd1, $urandom);
        push_beat(sakc_pkg::OP_QUERY, $urandom, x);
        push_beat(sakc_pkg::OP_QUERY, $urandom, x + 32'd1);
        push_beat(sakc_pkg::OP_QUERY, $urandom, x - 32'd1);
        build_set(30);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_beats.size() != 0 || s_valid || count_expect.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
design/sakc_pkg.sv
design/sakc_ctrl.sv
design/sakc_dpath.sv
design/sorted_array_key_count.sv
tb/sv/sorted_array_key_count_test.sv
